/* rtl/assert_macros.svh */
// Assertion macros shared by the hash unit RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/sha1le_pkg.sv */
// Shared types, constants and helpers of the little-endian SHA-1 hash unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha1le_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [6:0] LastRound  = 7'd79;
  localparam logic [6:0] LoadRounds = 7'd16;
  localparam logic [3:0] LenWordIdx = 4'd14;
  localparam logic [2:0] LastDigest = 3'd4;

  // One block word passed from the front end to the round engine.
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } blk_word_t;

  typedef enum logic [2:0] {
    FrData,
    FrPad,
    FrZero,
    FrLenLo,
    FrLenHi
  } fr_state_e;

  typedef enum logic [1:0] {
    BkRun,
    BkAdd,
    BkEmit
  } bk_state_e;

  // Round constant for round t.
  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    priority if (t < 7'd20) k = 32'h5A827999;
    else if (t < 7'd40)     k = 32'h6ED9EBA1;
    else if (t < 7'd60)     k = 32'h8F1BBCDC;
    else                    k = 32'hCA62C1D6;
    return k;
  endfunction

  // Initial chaining word i.
  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0:    h = H0;
      3'd1:    h = H1;
      3'd2:    h = H2;
      3'd3:    h = H3;
      default: h = H4;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

/* rtl/sha1le_front.sv */
// Front end: packs message bytes into block words, appends padding and length.
// Depends on sha1le_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha1le_front import sha1le_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] message_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        end_of_message_i,
  input  wire logic        push_i,
  output logic             full_o,
  output logic             q_push_o,
  output blk_word_t        q_data_o,
  input  wire logic        q_full_i
);

  fr_state_e   state_q, state_d;
  logic [23:0] carry_q, carry_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] total_q, total_d;

  logic [2:0]  n_bytes;
  logic [31:0] wmask;
  logic [55:0] merged;
  logic [2:0]  sum_bytes;
  logic [3:0]  widx_inc;
  logic        accept;

  // Clip the byte count and mask off invalid bytes
  always_comb begin
    n_bytes = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
    unique case (n_bytes)
      3'd0:    wmask = 32'h0000_0000;
      3'd1:    wmask = 32'h0000_00FF;
      3'd2:    wmask = 32'h0000_FFFF;
      3'd3:    wmask = 32'h00FF_FFFF;
      default: wmask = 32'hFFFF_FFFF;
    endcase
  end

  // Merge the held bytes with the new ones
  assign merged    = {32'b0, carry_q} | ({24'b0, message_word_i & wmask} << {fill_q[1:0], 3'b000});
  assign sum_bytes = {1'b0, fill_q[1:0]} + n_bytes;
  assign widx_inc  = fill_q[5:2] + 4'd1;
  assign full_o    = (state_q != FrData) || q_full_i;
  assign accept    = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrData;
      carry_q <= '0;
      fill_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      carry_q <= carry_d;
      fill_q  <= fill_d;
      total_q <= total_d;
    end
  end

  // Next state and queue writes
  always_comb begin
    state_d  = state_q;
    carry_d  = carry_q;
    fill_d   = fill_q;
    total_d  = total_q;
    q_push_o = 1'b0;
    q_data_o = '0;
    unique case (state_q)
      FrData: begin
        if (accept) begin
          fill_d  = fill_q + {3'b0, n_bytes};
          total_d = total_q + {58'b0, n_bytes, 3'b000};
          if (sum_bytes >= 3'd4) begin
            q_push_o      = 1'b1;
            q_data_o.word = merged[31:0];
            carry_d       = merged[55:32];
          end else begin
            carry_d = merged[23:0];
          end
          if (end_of_message_i) state_d = FrPad;
        end
      end
      FrPad: begin
        if (!q_full_i) begin
          q_push_o      = 1'b1;
          q_data_o.word = {8'b0, carry_q} | (32'h80 << {fill_q[1:0], 3'b000});
          carry_d       = '0;
          fill_d        = {widx_inc, 2'b00};
          state_d       = (widx_inc == LenWordIdx) ? FrLenLo : FrZero;
        end
      end
      FrZero: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          fill_d   = {widx_inc, 2'b00};
          if (widx_inc == LenWordIdx) state_d = FrLenLo;
        end
      end
      FrLenLo: begin
        if (!q_full_i) begin
          q_push_o      = 1'b1;
          q_data_o.word = total_q[31:0];
          fill_d        = {widx_inc, 2'b00};
          state_d       = FrLenHi;
        end
      end
      default: begin
        if (!q_full_i) begin
          q_push_o      = 1'b1;
          q_data_o.word = total_q[63:32];
          q_data_o.last = 1'b1;
          fill_d        = '0;
          total_d       = '0;
          carry_d       = '0;
          state_d       = FrData;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/sha1le_fifo.sv */
// Short word queue between the front end and the round engine.
// Depends on sha1le_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha1le_fifo import sha1le_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire blk_word_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output blk_word_t      data_o,
  output logic           empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  blk_word_t       mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Store words
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* rtl/sha1le_back.sv */
// Round engine: one SHA-1 round per cycle unless paused, chaining update, digest
// output register; it pauses on an empty queue or add/emit. Depends on sha1le_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha1le_back import sha1le_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire blk_word_t   q_data_i,
  input  wire logic        q_empty_i,
  output logic             q_pop_o,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o,
  output logic             empty_o,
  input  wire logic        pop_i
);

  bk_state_e   st_q, st_d;
  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] win_q [16];
  logic [6:0]  t_q;
  logic [2:0]  k_q;
  logic        last_q;
  logic        out_v_q;
  logic [31:0] out_word_q;
  logic [2:0]  out_idx_q;

  logic [31:0] sched, wt, f, tmp;
  logic [31:0] hsum [5];
  logic        step, do_add, emit, out_free;

  assign out_free = !out_v_q || pop_i;

  // Schedule word and round function
  always_comb begin
    sched = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
    wt    = (t_q < LoadRounds) ? q_data_i.word : {sched[30:0], sched[31]};
    priority if (t_q < 7'd20) f = (b_q & c_q) | (~b_q & d_q);
    else if (t_q < 7'd40)     f = b_q ^ c_q ^ d_q;
    else if (t_q < 7'd60)     f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
    else                      f = b_q ^ c_q ^ d_q;
    tmp = {a_q[26:0], a_q[31:27]} + f + e_q + round_k(t_q) + wt;
    hsum[0] = h_q[0] + a_q;
    hsum[1] = h_q[1] + b_q;
    hsum[2] = h_q[2] + c_q;
    hsum[3] = h_q[3] + d_q;
    hsum[4] = h_q[4] + e_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BkRun;
    else         st_q <= st_d;
  end

  // Sequence rounds, chaining add and digest output
  always_comb begin
    st_d    = st_q;
    q_pop_o = 1'b0;
    step    = 1'b0;
    do_add  = 1'b0;
    emit    = 1'b0;
    unique case (st_q)
      BkRun: begin
        if (t_q < LoadRounds) begin
          q_pop_o = !q_empty_i;
          step    = !q_empty_i;
        end else begin
          step = 1'b1;
        end
        if (step && t_q == LastRound) st_d = BkAdd;
      end
      BkAdd: begin
        do_add = 1'b1;
        st_d   = last_q ? BkEmit : BkRun;
      end
      default: begin
        if (out_free) begin
          emit = 1'b1;
          if (k_q == LastDigest) st_d = BkRun;
        end
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) h_q[i] <= init_h(3'(i));
      a_q <= H0; b_q <= H1; c_q <= H2; d_q <= H3; e_q <= H4;
      t_q        <= '0;
      k_q        <= '0;
      last_q     <= 1'b0;
      out_v_q    <= 1'b0;
      out_word_q <= '0;
      out_idx_q  <= '0;
    end else begin
      if (step) begin
        e_q <= d_q;
        d_q <= c_q;
        c_q <= {b_q[1:0], b_q[31:2]};
        b_q <= a_q;
        a_q <= tmp;
        for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
        win_q[15] <= wt;
        t_q <= (t_q == LastRound) ? '0 : t_q + 7'd1;
        if (t_q == LoadRounds - 7'd1) last_q <= q_data_i.last;
      end
      if (do_add) begin
        for (int i = 0; i < 5; i++) h_q[i] <= hsum[i];
        a_q <= hsum[0]; b_q <= hsum[1]; c_q <= hsum[2]; d_q <= hsum[3]; e_q <= hsum[4];
      end
      if (emit) begin
        out_v_q    <= 1'b1;
        out_word_q <= h_q[k_q];
        out_idx_q  <= k_q;
        if (k_q == LastDigest) begin
          k_q    <= '0;
          last_q <= 1'b0;
          for (int i = 0; i < 5; i++) h_q[i] <= init_h(3'(i));
          a_q <= H0; b_q <= H1; c_q <= H2; d_q <= H3; e_q <= H4;
        end else begin
          k_q <= k_q + 3'd1;
        end
      end else if (pop_i && out_v_q) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == LastDigest);
  assign empty_o       = !out_v_q;

endmodule
`default_nettype wire

/* rtl/sha1_little_endian_hash_unit.sv */
// Top level of the little-endian SHA-1 hash unit: front end, word queue, round engine.
// Depends on sha1le_pkg, sha1le_front, sha1le_fifo, sha1le_back, assert_macros.svh.
//
//  channel  | handshake   | payload
//  ---------+-------------+----------------------------------------------
//  input    | push / full | message_word_i, byte_count_i, end_of_message_i
//  result   | empty / pop | digest_word_o, word_index_o, last_word_o
//
// Each 16-word block runs all its rounds in the single round unit, then the chaining
// add. A final word adds up to 18 padding words, then five digest results, one a
// cycle while each result is popped. Reset (rst_ni low, asynchronous) empties the
// queue and restores the initial chaining words. Input stalls while the queue is
// full or padding is emitted.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha1_little_endian_hash_unit import sha1le_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] message_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        end_of_message_i,
  input  wire logic        push,
  output logic             full,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o,
  output logic             empty,
  input  wire logic        pop
);

  blk_word_t q_in, q_out;
  logic      q_push, q_full, q_pop, q_empty;

  // Accept and pad message bytes
  sha1le_front u_front (
    .clk_i, .rst_ni,
    .message_word_i, .byte_count_i, .end_of_message_i,
    .push_i   (push),
    .full_o   (full),
    .q_push_o (q_push),
    .q_data_o (q_in),
    .q_full_i (q_full)
  );

  // Buffer block words
  sha1le_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  // Run rounds and deliver the digest
  sha1le_back u_back (
    .clk_i, .rst_ni,
    .q_data_i  (q_out),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .digest_word_o, .word_index_o, .last_word_o,
    .empty_o   (empty),
    .pop_i     (pop)
  );

  `ASSERT_IMPL(a_no_push_full, q_full, !q_push)
  `ASSERT_IMPL(a_last_idx, !empty, last_word_o == (word_index_o == LastDigest))
  `ASSERT_NEXT(a_idx_seq, pop && !empty && !last_word_o, empty || word_index_o == 3'($past(word_index_o) + 3'd1))

endmodule
`default_nettype wire
